### src/gwp_pkg.sv
// ============================================================================
// gwp_pkg: shared types and constants for the G-code word parser
// Item structs for both channels, character codes and result kinds.
// ============================================================================
`default_nettype none

package gwp_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] feed;
      logic signed [31:0] radius;
   } rsp_item_type;

   // Character codes
   localparam logic [7:0] ASCII_0     = 8'd48;
   localparam logic [7:0] ASCII_9     = 8'd57;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;
   localparam logic [7:0] ASCII_DOT   = 8'h2E;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_NL    = 8'h0A;
   localparam logic [7:0] ASCII_G     = 8'h47;
   localparam logic [7:0] ASCII_M     = 8'h4D;
   localparam logic [7:0] ASCII_X     = 8'h58;
   localparam logic [7:0] ASCII_Y     = 8'h59;
   localparam logic [7:0] ASCII_Z     = 8'h5A;
   localparam logic [7:0] ASCII_F     = 8'h46;
   localparam logic [7:0] ASCII_R     = 8'h52;

   // Result kinds
   localparam logic [2:0] KIND_G1_MOVE   = 3'd0;
   localparam logic [2:0] KIND_G2_ARC    = 3'd1;
   localparam logic [2:0] KIND_M1        = 3'd2;
   localparam logic [2:0] KIND_M2        = 3'd3;
   localparam logic [2:0] KIND_BAD_START = 3'd4;
   localparam logic [2:0] KIND_MISSING   = 3'd5;

   // A digit weighted by a power of ten; the largest value, 9e6, fits in 24 bits.
   localparam int WEIGHT_WIDTH = 24;

   function automatic logic [WEIGHT_WIDTH-1:0] digit_weight(input logic [3:0] digit,
                                                            input logic [2:0] expo);
      logic [WEIGHT_WIDTH-1:0] pw;
      case (expo)
         3'd0:    pw = 24'd1;
         3'd1:    pw = 24'd10;
         3'd2:    pw = 24'd100;
         3'd3:    pw = 24'd1000;
         3'd4:    pw = 24'd10000;
         3'd5:    pw = 24'd100000;
         3'd6:    pw = 24'd1000000;
         default: pw = 24'd0;
      endcase
      return WEIGHT_WIDTH'(pw * {20'd0, digit});
   endfunction

endpackage

`default_nettype wire

### src/gwp_in_stage.sv
// ============================================================================
// gwp_in_stage: input register
// Holds one accepted character item until the parser core consumes it.
// ============================================================================
`default_nettype none

module gwp_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire gwp_pkg::req_item_type req_item,
   input  wire logic                  take,
   output logic                       full,
   output gwp_pkg::req_item_type      item
);

   logic                  full_ff;
   logic                  full_in;
   gwp_pkg::req_item_type item_ff;
   logic                  accept;

   // A held item blocks the channel only when the core cannot take it this cycle.
   assign req_stall = full_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         full_in = 1'b1;
      end else if (take) begin
         full_in = 1'b0;
      end else begin
         full_in = full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign full = full_ff;
   assign item = item_ff;

endmodule

`default_nettype wire

### src/gwp_line_core.sv
// ============================================================================
// gwp_line_core: line parser state and per-character update
// Tracks the line phase, command, current word and modal values, and forms
// the result item when a line closes.
// ============================================================================
`default_nettype none

module gwp_line_core #(
   parameter int FRAC_DIGITS = 3,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire gwp_pkg::req_item_type item,
   output logic                       emit,
   output gwp_pkg::rsp_item_type      result
);

   localparam logic [2:0] PH_START = 3'd0;
   localparam logic [2:0] PH_CMD   = 3'd1;
   localparam logic [2:0] PH_GAP   = 3'd2;
   localparam logic [2:0] PH_INT   = 3'd3;
   localparam logic [2:0] PH_FRAC  = 3'd4;
   localparam logic [2:0] PH_SKIP  = 3'd5;

   localparam logic [2:0] WL_NONE = 3'd0;
   localparam logic [2:0] WL_X    = 3'd1;
   localparam logic [2:0] WL_Y    = 3'd2;
   localparam logic [2:0] WL_Z    = 3'd3;
   localparam logic [2:0] WL_F    = 3'd4;
   localparam logic [2:0] WL_R    = 3'd5;

   localparam int SW = (VALUE_WIDTH + 5 > 25) ? VALUE_WIDTH + 5 : 25;
   localparam logic [VALUE_WIDTH-1:0] VCAP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   function automatic logic signed [31:0] to_field(input logic [VALUE_WIDTH-1:0] v);
      logic signed [VALUE_WIDTH-1:0] s;
      logic signed [63:0]            w;
      s = v;
      w = 64'(s);
      return w[31:0];
   endfunction

   logic [2:0]             phase_ff, phase_in;
   logic                   is_m_ff, is_m_in;
   logic [6:0]             cmd_ff, cmd_in;
   logic [2:0]             letter_ff, letter_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [2:0]             fc_ff, fc_in;
   logic                   neg_ff, neg_in;
   logic                   err_ff, err_in;
   logic [VALUE_WIDTH-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [VALUE_WIDTH-1:0] feed_ff, feed_in, radius_ff, radius_in;
   logic                   feed_seen_ff, feed_seen_in;
   logic                   radius_seen_ff, radius_seen_in;

   logic [7:0]             c;
   logic                   eoi, is_nl, is_digit;
   logic [7:0]             dsub;
   logic [3:0]             dv;
   logic [2:0]             frac_exp;
   logic [SW-1:0]          int_sum, frac_sum;
   logic [VALUE_WIDTH-1:0] int_mag, frac_mag;
   logic [10:0]            cmd_sum;
   logic [VALUE_WIDTH-1:0] cval;
   logic                   closing, commit;
   logic [VALUE_WIDTH-1:0] x_cl, y_cl, z_cl, feed_cl, radius_cl;
   logic                   fs_cl, rs_cl;
   logic [2:0]             kind;
   logic                   kind_ok;

   assign c        = item.ch;
   assign eoi      = item.end_of_input;
   assign is_nl    = (c == gwp_pkg::ASCII_NL);
   assign is_digit = (c >= gwp_pkg::ASCII_0) && (c <= gwp_pkg::ASCII_9);
   assign dsub     = c - gwp_pkg::ASCII_0;
   assign dv       = dsub[3:0];

   // The magnitude is kept already scaled to the full fraction, saturated at VCAP.
   // An integer digit scales it by ten; a fraction digit adds at its own place.
   assign frac_exp = 3'(FRAC_DIGITS - 1 - int'(fc_ff));
   assign int_sum  = (SW'(mag_ff) << 3) + (SW'(mag_ff) << 1)
                   + SW'(gwp_pkg::digit_weight(dv, 3'(FRAC_DIGITS)));
   assign frac_sum = SW'(mag_ff) + SW'(gwp_pkg::digit_weight(dv, frac_exp));
   assign int_mag  = (int_sum > SW'(VCAP)) ? VCAP : int_sum[VALUE_WIDTH-1:0];
   assign frac_mag = (frac_sum > SW'(VCAP)) ? VCAP : frac_sum[VALUE_WIDTH-1:0];

   assign cmd_sum = (11'(cmd_ff) << 3) + (11'(cmd_ff) << 1) + 11'(dv);

   always_comb begin
      if (neg_ff) begin
         cval = ~mag_ff + VALUE_WIDTH'(1);
      end else if (mag_ff == VCAP) begin
         cval = VCAP - VALUE_WIDTH'(1);
      end else begin
         cval = mag_ff;
      end
   end

   assign closing = (phase_ff != PH_START) && (eoi || is_nl);
   assign commit  = closing && ((phase_ff == PH_INT) || (phase_ff == PH_FRAC));

   // Values as they stand once the open word, if any, has been stored.
   assign x_cl      = (commit && letter_ff == WL_X) ? cval : x_ff;
   assign y_cl      = (commit && letter_ff == WL_Y) ? cval : y_ff;
   assign z_cl      = (commit && letter_ff == WL_Z) ? cval : z_ff;
   assign feed_cl   = (commit && letter_ff == WL_F) ? cval : feed_ff;
   assign radius_cl = (commit && letter_ff == WL_R) ? cval : radius_ff;
   assign fs_cl     = feed_seen_ff || (commit && letter_ff == WL_F);
   assign rs_cl     = radius_seen_ff || (commit && letter_ff == WL_R);

   always_comb begin
      kind    = gwp_pkg::KIND_BAD_START;
      kind_ok = 1'b0;
      if (err_ff) begin
         kind    = gwp_pkg::KIND_BAD_START;
         kind_ok = 1'b1;
      end else if (!is_m_ff) begin
         if (cmd_ff == 7'd1) begin
            kind    = fs_cl ? gwp_pkg::KIND_G1_MOVE : gwp_pkg::KIND_MISSING;
            kind_ok = 1'b1;
         end else if (cmd_ff == 7'd2) begin
            kind    = (fs_cl && rs_cl) ? gwp_pkg::KIND_G2_ARC : gwp_pkg::KIND_MISSING;
            kind_ok = 1'b1;
         end
      end else begin
         if (cmd_ff == 7'd1) begin
            kind    = gwp_pkg::KIND_M1;
            kind_ok = 1'b1;
         end else if (cmd_ff == 7'd2) begin
            kind    = gwp_pkg::KIND_M2;
            kind_ok = 1'b1;
         end
      end
   end

   assign emit          = closing && kind_ok;
   assign result.kind   = kind;
   assign result.pos_x  = to_field(x_cl);
   assign result.pos_y  = to_field(y_cl);
   assign result.pos_z  = to_field(z_cl);
   assign result.feed   = fs_cl ? to_field(feed_cl) : 32'sd0;
   assign result.radius = rs_cl ? to_field(radius_cl) : 32'sd0;

   always_comb begin
      phase_in       = phase_ff;
      is_m_in        = is_m_ff;
      cmd_in         = cmd_ff;
      letter_in      = letter_ff;
      mag_in         = mag_ff;
      fc_in          = fc_ff;
      neg_in         = neg_ff;
      err_in         = err_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      feed_in        = feed_ff;
      radius_in      = radius_ff;
      feed_seen_in   = feed_seen_ff;
      radius_seen_in = radius_seen_ff;
      if (step) begin
         if (phase_ff == PH_START) begin
            if (!eoi && !is_nl) begin
               if ((c == gwp_pkg::ASCII_G) || (c == gwp_pkg::ASCII_M)) begin
                  is_m_in  = (c == gwp_pkg::ASCII_M);
                  cmd_in   = 7'd0;
                  phase_in = PH_CMD;
               end else begin
                  err_in   = 1'b1;
                  phase_in = PH_SKIP;
               end
            end
         end else if (closing) begin
            x_in           = x_cl;
            y_in           = y_cl;
            z_in           = z_cl;
            feed_in        = feed_cl;
            radius_in      = radius_cl;
            phase_in       = PH_START;
            feed_seen_in   = 1'b0;
            radius_seen_in = 1'b0;
            err_in         = 1'b0;
            letter_in      = WL_NONE;
         end else begin
            unique case (phase_ff) inside
               PH_CMD: begin
                  if (is_digit) begin
                     cmd_in = (cmd_sum > 11'd127) ? 7'd127 : cmd_sum[6:0];
                  end else if (c == gwp_pkg::ASCII_SPACE) begin
                     phase_in = PH_GAP;
                  end
               end
               PH_GAP: begin
                  if (c != gwp_pkg::ASCII_SPACE) begin
                     unique case (c)
                        gwp_pkg::ASCII_X: letter_in = WL_X;
                        gwp_pkg::ASCII_Y: letter_in = WL_Y;
                        gwp_pkg::ASCII_Z: letter_in = WL_Z;
                        gwp_pkg::ASCII_F: letter_in = WL_F;
                        gwp_pkg::ASCII_R: letter_in = WL_R;
                        default:          letter_in = WL_NONE;
                     endcase
                     mag_in   = '0;
                     fc_in    = 3'd0;
                     neg_in   = 1'b0;
                     phase_in = PH_INT;
                  end
               end
               PH_INT, PH_FRAC: begin
                  if (is_digit) begin
                     if (phase_ff == PH_INT) begin
                        mag_in = int_mag;
                     end else if (int'(fc_ff) < FRAC_DIGITS) begin
                        mag_in = frac_mag;
                        fc_in  = fc_ff + 3'd1;
                     end
                  end else if (c == gwp_pkg::ASCII_MINUS) begin
                     neg_in = 1'b1;
                  end else if (c == gwp_pkg::ASCII_DOT) begin
                     phase_in = PH_FRAC;
                  end else if (c == gwp_pkg::ASCII_SPACE) begin
                     unique case (letter_ff)
                        WL_X:    x_in = cval;
                        WL_Y:    y_in = cval;
                        WL_Z:    z_in = cval;
                        WL_F: begin
                           feed_in      = cval;
                           feed_seen_in = 1'b1;
                        end
                        WL_R: begin
                           radius_in      = cval;
                           radius_seen_in = 1'b1;
                        end
                        default: ;
                     endcase
                     phase_in = PH_GAP;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         is_m_ff        <= 1'b0;
         cmd_ff         <= 7'd0;
         letter_ff      <= WL_NONE;
         mag_ff         <= '0;
         fc_ff          <= 3'd0;
         neg_ff         <= 1'b0;
         err_ff         <= 1'b0;
         x_ff           <= '0;
         y_ff           <= '0;
         z_ff           <= '0;
         feed_ff        <= '0;
         radius_ff      <= '0;
         feed_seen_ff   <= 1'b0;
         radius_seen_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         is_m_ff        <= is_m_in;
         cmd_ff         <= cmd_in;
         letter_ff      <= letter_in;
         mag_ff         <= mag_in;
         fc_ff          <= fc_in;
         neg_ff         <= neg_in;
         err_ff         <= err_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
         z_ff           <= z_in;
         feed_ff        <= feed_in;
         radius_ff      <= radius_in;
         feed_seen_ff   <= feed_seen_in;
         radius_seen_ff <= radius_seen_in;
      end
   end

endmodule

`default_nettype wire

### src/gcode_word_parser.sv
// ============================================================================
// gcode_word_parser: G-code line parser, one character item per cycle while no result is stalled
// The result of a line is registered in the output register once the core steps the closing item.
// Throughput: one character item per cycle while no result is held back by rsp_stall.
// A result waiting on rsp_stall holds the parser, so the input register fills and
// req_stall stays high until that result is taken.
// Reset: synchronous; parser returns to line start, coordinates, feed and radius clear.
// ============================================================================
`default_nettype none

module gcode_word_parser #(
   parameter int FRAC_DIGITS = 3,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire gwp_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output gwp_pkg::rsp_item_type      rsp_item
);

   logic                  in_full;
   gwp_pkg::req_item_type in_item;
   logic                  out_free;
   logic                  step;
   logic                  emit;
   gwp_pkg::rsp_item_type result;
   logic                  rsp_valid_ff, rsp_valid_in;
   gwp_pkg::rsp_item_type rsp_item_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step     = in_full && out_free;

   gwp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .take      (out_free),
      .full      (in_full),
      .item      (in_item)
   );

   gwp_line_core #(
      .FRAC_DIGITS (FRAC_DIGITS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_line_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item),
      .emit   (emit),
      .result (result)
   );

   always_comb begin
      if (out_free) begin
         rsp_valid_in = step && emit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire
